[rtl/mhb_pkg.sv]
// Shared types and constants for the streaming 64-bit murmur hash unit.
// Used by the front end, the request queue and the back end. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mhb_pkg;

   localparam logic [31:0] MIX_MUL       = 32'h5bd1e995;
   localparam int unsigned MIX_SHIFT     = 24;
   localparam logic [31:0] MAX_KEY_BYTES = 32'd65535;

   localparam int unsigned FIN_SHIFT_0 = 18;
   localparam int unsigned FIN_SHIFT_1 = 22;
   localparam int unsigned FIN_SHIFT_2 = 17;
   localparam int unsigned FIN_SHIFT_3 = 19;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned RSP_DATA_W = 64;

   typedef enum logic [1:0] {
      WORD_NONE,
      WORD_FULL,
      WORD_PART
   } word_kind_type;

   typedef struct packed {
      word_kind_type kind;
      logic [31:0]   data;
      logic          first;
      logic          last;
      logic [31:0]   seed_len;
   } queue_entry_type;

endpackage : mhb_pkg

`default_nettype wire

[rtl/murmur_hash_64b_stream_unit.sv]
// Top level of the streaming 64-bit murmur hash unit.
// Instantiates mhb_front, mhb_queue and mhb_back; uses mhb_pkg.
//
//   Channel   Direction  Payload
//   req_*     in         key words with seed, length, first and last marks
//   rsp_*     out        64-bit hash, one per key
//
// A request passes two front stages (one multiply each) into a four-entry queue.
// The back end folds one request per cycle with a single multiply while it is idle.
// A last request adds the finalization steps FIN0 to FIN3, one multiply each, before
// the hash of the key is registered at the output.
// Reset clears the accumulators, the queue and the output valid.
// Either side can stall independently; a held result stalls the last finalization step and so the back end.
`timescale 1ns / 1ps
`default_nettype none

module murmur_hash_64b_stream_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // key_word[31:0], valid_bytes[34:32], hash_seed[66:35], key_length[82:67], zero pad
   input  wire logic [mhb_pkg::REQ_DATA_W-1:0]    req_tdata,
   // first_word
   input  wire logic                              req_tuser,
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // hash_value[63:0]
   output logic [mhb_pkg::RSP_DATA_W-1:0]         rsp_tdata
);

   logic                      push;
   logic                      pop;
   logic                      queue_full;
   logic                      queue_empty;
   mhb_pkg::queue_entry_type  push_entry;
   mhb_pkg::queue_entry_type  pop_entry;
   logic [4:0]                pad_unused;

   assign pad_unused = req_tdata[87:83];

   mhb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .key_word    (req_tdata[31:0]),
      .valid_bytes (req_tdata[34:32]),
      .first_word  (req_tuser),
      .last_word   (req_tlast),
      .hash_seed   (req_tdata[66:35]),
      .key_length  (req_tdata[82:67]),
      .push        (push),
      .push_entry  (push_entry),
      .queue_full  (queue_full)
   );

   mhb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   mhb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (queue_empty),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule : murmur_hash_64b_stream_unit

`default_nettype wire

[rtl/mhb_front.sv]
// Front end: accepts key words, classifies them and runs the two-stage word mix.
// Depends on mhb_pkg; feeds mhb_queue.
`timescale 1ns / 1ps
`default_nettype none

module mhb_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [31:0]                 key_word,
   input  wire logic [2:0]                  valid_bytes,
   input  wire logic                        first_word,
   input  wire logic                        last_word,
   input  wire logic [31:0]                 hash_seed,
   input  wire logic [15:0]                 key_length,
   output logic                             push,
   output mhb_pkg::queue_entry_type         push_entry,
   input  wire logic                        queue_full
);

   logic                      a_vld_ff, a_vld_in;
   logic                      b_vld_ff, b_vld_in;
   mhb_pkg::queue_entry_type  a_ent_ff, a_ent_in;
   mhb_pkg::queue_entry_type  b_ent_ff, b_ent_in;
   logic                      a_en, b_en;
   logic [31:0]               mask;
   logic [31:0]               len_ext;
   logic [31:0]               len_sat;
   logic [31:0]               mix_t;

   assign push       = b_vld_ff && !queue_full;
   assign push_entry = b_ent_ff;
   assign b_en       = !b_vld_ff || !queue_full;
   assign a_en       = !a_vld_ff || b_en;
   assign req_tready = a_en;

   always_comb begin
      case (valid_bytes)
         3'd1:    mask = 32'h0000_00ff;
         3'd2:    mask = 32'h0000_ffff;
         3'd3:    mask = 32'h00ff_ffff;
         default: mask = 32'hffff_ffff;
      endcase
      len_ext = {16'd0, key_length};
      len_sat = (len_ext > mhb_pkg::MAX_KEY_BYTES) ? mhb_pkg::MAX_KEY_BYTES : len_ext;

      a_ent_in          = a_ent_ff;
      a_ent_in.first    = first_word;
      a_ent_in.last     = last_word;
      a_ent_in.seed_len = hash_seed ^ len_sat;
      if (valid_bytes == 3'd0) begin
         a_ent_in.kind = mhb_pkg::WORD_NONE;
         a_ent_in.data = key_word;
      end else if (valid_bytes >= 3'd4) begin
         a_ent_in.kind = mhb_pkg::WORD_FULL;
         a_ent_in.data = key_word * mhb_pkg::MIX_MUL;
      end else begin
         a_ent_in.kind = mhb_pkg::WORD_PART;
         a_ent_in.data = key_word & mask;
      end
      a_vld_in = a_en ? req_tvalid : a_vld_ff;

      mix_t    = a_ent_ff.data ^ (a_ent_ff.data >> mhb_pkg::MIX_SHIFT);
      b_ent_in = a_ent_ff;
      if (a_ent_ff.kind == mhb_pkg::WORD_FULL) begin
         b_ent_in.data = mix_t * mhb_pkg::MIX_MUL;
      end
      b_vld_in = b_en ? a_vld_ff : b_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
      end
      if (a_en) begin
         a_ent_ff <= a_ent_in;
      end
      if (b_en) begin
         b_ent_ff <= b_ent_in;
      end
   end

endmodule : mhb_front

`default_nettype wire

[rtl/mhb_queue.sv]
// Short register queue of mixed words between the front end and the back end.
// Depends on mhb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mhb_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire mhb_pkg::queue_entry_type    push_entry,
   output logic                             full,
   input  wire logic                        pop,
   output mhb_pkg::queue_entry_type         pop_entry,
   output logic                             empty
);

   mhb_pkg::queue_entry_type        mem_ff [mhb_pkg::QUEUE_DEPTH];
   logic [mhb_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mhb_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [mhb_pkg::QUEUE_AW:0]      count_ff, count_in;

   assign full      = (count_ff == (mhb_pkg::QUEUE_AW+1)'(mhb_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule : mhb_queue

`default_nettype wire

[rtl/mhb_back.sv]
// Back end: folds mixed words into the two accumulators and runs finalization.
// Depends on mhb_pkg; drains mhb_queue and drives the hash output register.
`timescale 1ns / 1ps
`default_nettype none

module mhb_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        empty,
   input  wire mhb_pkg::queue_entry_type    pop_entry,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [mhb_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIN0,
      ST_FIN1,
      ST_FIN2,
      ST_FIN3
   } state_type;

   state_type                      state_ff, state_in;
   logic [31:0]                    h1_ff, h1_in;
   logic [31:0]                    h2_ff, h2_in;
   logic                           odd_ff, odd_in;
   logic [31:0]                    fa_ff, fa_in;
   logic [31:0]                    fb_ff, fb_in;
   logic                           rsp_vld_ff, rsp_vld_in;
   logic [mhb_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [31:0]                    base1, base2;
   logic                           base_odd;
   logic [31:0]                    mul_op;
   logic [31:0]                    prod;
   logic [31:0]                    fin_op;
   logic [31:0]                    fin_prod;
   logic [31:0]                    acc1, acc2;
   logic                           acc_odd;
   logic                           out_free;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign pop        = (state_ff == ST_IDLE) && !empty;

   always_comb begin
      base1    = pop_entry.first ? pop_entry.seed_len : h1_ff;
      base2    = pop_entry.first ? 32'd0 : h2_ff;
      base_odd = pop_entry.first ? 1'b0 : odd_ff;

      if (pop_entry.kind == mhb_pkg::WORD_FULL) begin
         mul_op = base_odd ? base2 : base1;
      end else begin
         mul_op = base2 ^ pop_entry.data;
      end
      prod = mul_op * mhb_pkg::MIX_MUL;

      acc1    = base1;
      acc2    = base2;
      acc_odd = base_odd;
      case (pop_entry.kind)
         mhb_pkg::WORD_FULL: begin
            if (base_odd) begin
               acc2 = prod ^ pop_entry.data;
            end else begin
               acc1 = prod ^ pop_entry.data;
            end
            acc_odd = !base_odd;
         end
         mhb_pkg::WORD_PART: begin
            acc2 = prod;
         end
         default: begin
         end
      endcase

      case (state_ff)
         ST_FIN0: fin_op = fa_ff ^ (fb_ff >> mhb_pkg::FIN_SHIFT_0);
         ST_FIN1: fin_op = fb_ff ^ (fa_ff >> mhb_pkg::FIN_SHIFT_1);
         ST_FIN2: fin_op = fa_ff ^ (fb_ff >> mhb_pkg::FIN_SHIFT_2);
         default: fin_op = fb_ff ^ (fa_ff >> mhb_pkg::FIN_SHIFT_3);
      endcase
      fin_prod = fin_op * mhb_pkg::MIX_MUL;

      state_in    = state_ff;
      h1_in       = h1_ff;
      h2_in       = h2_ff;
      odd_in      = odd_ff;
      fa_in       = fa_ff;
      fb_in       = fb_ff;
      rsp_data_in = rsp_data_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               h1_in  = acc1;
               h2_in  = acc2;
               odd_in = acc_odd;
               fa_in  = acc1;
               fb_in  = acc2;
               if (pop_entry.last) begin
                  state_in = ST_FIN0;
               end
            end
         end
         ST_FIN0: begin
            fa_in    = fin_prod;
            state_in = ST_FIN1;
         end
         ST_FIN1: begin
            fb_in    = fin_prod;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            fa_in    = fin_prod;
            state_in = ST_FIN3;
         end
         ST_FIN3: begin
            if (out_free) begin
               rsp_data_in = {fa_ff, fin_prod};
               rsp_vld_in  = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         h1_ff      <= '0;
         h2_ff      <= '0;
         odd_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         h1_ff      <= h1_in;
         h2_ff      <= h2_in;
         odd_ff     <= odd_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      fa_ff       <= fa_in;
      fb_ff       <= fb_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule : mhb_back

`default_nettype wire
